FILE: rtl/core/bds_pkg.sv
package bds_pkg;

    localparam int PIXEL_BITS    = 16;
    localparam int LINE_BITS     = PIXEL_BITS + 1;
    localparam int WIDTH_BITS    = 12;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(2048);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(2048);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // How the output pixel is formed from the 2x2 block
    typedef enum logic [1:0] {
        OP_QUAD = 2'd0,   // full block, sum >> 2
        OP_VERT = 2'd1,   // last column of odd width, vertical pair >> 1
        OP_HORZ = 2'd2,   // last row of odd height, horizontal pair >> 1
        OP_COPY = 2'd3    // corner when both are odd
    } t_avg_op;

    typedef struct packed {
        logic                 valid;
        logic                 emit;
        logic                 last;
        t_avg_op              op;
        logic [LINE_BITS-1:0] pair;
        logic [PIXEL_BITS-1:0] px;
    } t_s1;

endpackage

FILE: rtl/core/bds_in_if.sv
interface bds_in_if;
    logic                            valid;
    logic                            ready;
    logic [bds_pkg::PIXEL_BITS-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: rtl/core/bds_out_if.sv
interface bds_out_if;
    logic                            valid;
    logic                            ready;
    logic [bds_pkg::PIXEL_BITS-1:0]  out_pixel;
    logic                            last;

    modport source (output valid, output out_pixel, output last, input ready);
    modport sink   (input valid, input out_pixel, input last, output ready);
endinterface

FILE: rtl/core/bds_ram.sv
module bds_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/box_downsample_2x2.sv
// 2x2 box downsampler, raster in, raster out.
// Input transaction to output valid: registered into s1 with the line store read, then into the output reg.
// Throughput: 1 input pixel per cycle while the output is not stalled, set by the
// single-port-per-cycle line store (even rows only write it, odd rows only read it).
// Reset (sync, active low): counters, held pixel, pipeline valids cleared; width and
// height return to 2048. Line store is not cleared: every entry is written before use.
module box_downsample_2x2 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    bds_in_if.sink                               i_pix,
    bds_out_if.source                            o_pix,
    input  logic                                 i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import bds_pkg::*;

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int EB = (WB > WIDTH_BITS) ? WB : WIDTH_BITS;

    // configuration
    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero reads as one, width clamps to MAX_WIDTH
    logic [EB-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;

    always_comb begin
        w_eff = (r_width == '0) ? EB'(1) : EB'(r_width);
        if (w_eff > EB'(MAX_WIDTH)) begin
            w_eff = EB'(MAX_WIDTH);
        end
        h_eff = (r_height == '0) ? HEIGHT_BITS'(1) : r_height;
    end

    // stage 0: position, pair sum, line store access
    logic [CW-1:0]          r_col;
    logic [HEIGHT_BITS-1:0] r_row;
    logic [PIXEL_BITS-1:0]  r_held;
    t_s1                    r_s1;

    logic                   in_fire;
    logic                   s1_adv;
    logic                   col_last, row_last, col_odd, row_odd, col_emit;
    logic [PIXEL_BITS-1:0]  px;
    logic [LINE_BITS-1:0]   pair;
    logic [AW-1:0]          idx;
    logic                   ram_we, ram_re;
    logic [LINE_BITS-1:0]   ram_wdata, ram_q;

    assign px       = i_pix.pixel;
    assign col_last = (EB'(r_col) + EB'(1)) >= w_eff;
    assign row_last = ({1'b0, r_row} + 17'd1) >= {1'b0, h_eff};
    assign col_odd  = r_col[0];
    assign row_odd  = r_row[0];
    assign col_emit = col_odd || col_last;
    assign pair     = {1'b0, r_held} + {1'b0, px};
    assign idx      = AW'(r_col >> 1);

    // output register parts the two sides; s1 holds a transaction whose line data is pending
    logic                  r_o_valid;
    logic [PIXEL_BITS-1:0] r_o_pixel;
    logic                  r_o_last;

    assign s1_adv      = r_s1.valid && (!r_s1.emit || !r_o_valid || o_pix.ready);
    assign i_pix.ready = !r_s1.valid || s1_adv;
    assign in_fire     = i_pix.valid && i_pix.ready;

    // even rows only write, odd rows only read: no same-entry overlap in one cycle
    assign ram_we    = in_fire && !row_odd && col_emit;
    assign ram_wdata = col_odd ? pair : LINE_BITS'(px);
    assign ram_re    = in_fire && row_odd && col_emit;

    bds_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (idx),
        .o_rdata (ram_q)
    );

    t_s1 n_s1;

    always_comb begin
        n_s1       = r_s1;
        n_s1.valid = 1'b0;
        if (in_fire) begin
            n_s1.valid = 1'b1;
            n_s1.emit  = row_odd ? col_emit : (row_last && col_emit);
            n_s1.last  = row_last && col_last;
            n_s1.pair  = pair;
            n_s1.px    = px;
            if (row_odd) begin
                n_s1.op = col_odd ? OP_QUAD : OP_VERT;
            end else begin
                n_s1.op = col_odd ? OP_HORZ : OP_COPY;
            end
        end else if (r_s1.valid && !s1_adv) begin
            n_s1.valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            if (in_fire) begin
                if (!col_odd) begin
                    r_held <= px;
                end
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + HEIGHT_BITS'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // stage 1: finish the average
    logic [LINE_BITS:0]    quad_sum, vert_sum;
    logic [PIXEL_BITS-1:0] avg;

    assign quad_sum = {1'b0, ram_q} + {1'b0, r_s1.pair};
    assign vert_sum = {1'b0, ram_q} + (LINE_BITS + 1)'(r_s1.px);

    always_comb begin
        case (r_s1.op)
            OP_QUAD: avg = quad_sum[LINE_BITS:2];
            OP_VERT: avg = vert_sum[PIXEL_BITS:1];
            OP_HORZ: avg = r_s1.pair[PIXEL_BITS:1];
            OP_COPY: avg = r_s1.px;
            default: avg = r_s1.px;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (s1_adv && r_s1.emit) begin
                r_o_valid <= 1'b1;
                r_o_pixel <= avg;
                r_o_last  <= r_s1.last;
            end else if (o_pix.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid     = r_o_valid;
    assign o_pix.out_pixel = r_o_pixel;
    assign o_pix.last      = r_o_last;

`ifndef SYNTHESIS
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in the same cycle");

    a_read_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_s1.valid && (r_s1.op == OP_QUAD || r_s1.op == OP_VERT))
        else $error("line read not followed by an odd-row average");

    // a stalled odd-row transaction always issued a line read
    a_q_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && !s1_adv && (r_s1.op == OP_QUAD || r_s1.op == OP_VERT))
            |=> $stable(ram_q))
        else $error("line read data lost while stalled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_s1.emit && r_o_valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while result path is blocked");
`endif

endmodule
